FILE: hw/rtl/variable_length_bit_packer_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the variable-length bit packer
// Clocked, reset-qualified same-cycle and next-cycle implication checks.
// ----------------------------------------------------------------------------
`ifndef VARIABLE_LENGTH_BIT_PACKER_TOP_ASSERT_SVH
`define VARIABLE_LENGTH_BIT_PACKER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VLBP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bit packer check failed");

// The consequent must hold in the cycle after the antecedent.
`define VLBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bit packer check failed");

`endif

FILE: hw/rtl/vlbp_pkg.sv
// ----------------------------------------------------------------------------
// Variable-length bit packer package
// Shared constants and the command type passed from the front to the back.
// ----------------------------------------------------------------------------
package vlbp_pkg;

	localparam int unsigned BYTE_BITS   = 8;
	localparam int unsigned WIDTH_BITS  = 4;
	localparam int unsigned QUEUE_DEPTH = 4;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_FLUSH  = 1'b1
	} action_t;

	typedef struct packed {
		action_t                 action;
		logic [BYTE_BITS-1:0]    bits;
		logic [WIDTH_BITS-1:0]   width;
	} cmd_t;

endpackage

FILE: hw/rtl/vlbp_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Small register queue that decouples the classifying front from the packer.
// ----------------------------------------------------------------------------
module vlbp_queue #(
	parameter int unsigned Depth = vlbp_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  vlbp_pkg::cmd_t    push_cmd,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output vlbp_pkg::cmd_t    head_cmd
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	vlbp_pkg::cmd_t entry_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (count_q == CntW'(Depth));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/vlbp_front.sv
// ----------------------------------------------------------------------------
// Packer front end
// Accepts items, clamps the width, masks the field bits and reverses them for MSB-first items, and
// drops inserts of width zero before they reach the command queue.
// ----------------------------------------------------------------------------
module vlbp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  vlbp_pkg::action_t in_action,
	input  logic [7:0]        in_bits,
	input  logic [3:0]        in_width,
	input  logic              in_msb_first,
	output logic              push,
	output vlbp_pkg::cmd_t    push_cmd,
	input  logic              queue_full
);

	logic           valid_s1;
	vlbp_pkg::cmd_t cmd_s1;
	vlbp_pkg::cmd_t cmd_next;
	logic [3:0]     width_clamped;
	logic [7:0]     mask;
	logic [7:0]     masked;
	logic [7:0]     reversed;
	logic           keep;
	logic           accept;

	always_comb begin
		width_clamped = (in_width > 4'(vlbp_pkg::BYTE_BITS)) ? 4'(vlbp_pkg::BYTE_BITS)
			: in_width;
		mask   = 8'hFF >> (4'(vlbp_pkg::BYTE_BITS) - width_clamped);
		masked = in_bits & mask;
		for (int i = 0; i < 8; i++) begin
			reversed[i] = masked[7 - i];
		end
		reversed = reversed >> (4'(vlbp_pkg::BYTE_BITS) - width_clamped);

		cmd_next.action = in_action;
		if (in_action == vlbp_pkg::ACT_FLUSH) begin
			cmd_next.bits  = '0;
			cmd_next.width = '0;
		end else begin
			cmd_next.bits  = in_msb_first ? reversed : masked;
			cmd_next.width = width_clamped;
		end
		keep = (in_action == vlbp_pkg::ACT_FLUSH) || (in_width != '0);
	end

	assign push     = valid_s1 && !queue_full;
	assign in_ready = !valid_s1 || !queue_full;
	assign accept   = in_valid && in_ready;
	assign push_cmd = cmd_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule

FILE: hw/rtl/vlbp_back.sv
// ----------------------------------------------------------------------------
// Packer back end
// Merges queued fields into the byte under construction and registers each
// completed or flushed byte for the output channel.
// ----------------------------------------------------------------------------
module vlbp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           queue_empty,
	input  vlbp_pkg::cmd_t head_cmd,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic [3:0]     out_valid_bits,
	output logic           out_flushed
);

	logic [7:0]  partial_q;
	logic [2:0]  fill_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic [3:0]  out_bits_q;
	logic        out_flushed_q;

	logic [15:0] shifted;
	logic [15:0] combined;
	logic [3:0]  total;
	logic        emit;
	logic [7:0]  emit_byte;
	logic [3:0]  emit_bits;
	logic [7:0]  partial_next;
	logic [2:0]  fill_next;

	always_comb begin
		shifted   = {8'h00, head_cmd.bits} << fill_q;
		combined  = {8'h00, partial_q} | shifted;
		total     = {1'b0, fill_q} + head_cmd.width;
		emit      = 1'b0;
		emit_byte = combined[7:0];
		emit_bits = 4'(vlbp_pkg::BYTE_BITS);
		partial_next = combined[7:0];
		fill_next    = total[2:0];
		if (head_cmd.action == vlbp_pkg::ACT_FLUSH) begin
			emit         = (fill_q != '0);
			emit_byte    = partial_q;
			emit_bits    = {1'b0, fill_q};
			partial_next = '0;
			fill_next    = '0;
		end else if (total[3]) begin
			emit         = 1'b1;
			partial_next = combined[15:8];
			fill_next    = total[2:0];
		end
	end

	assign pop            = !queue_empty && (!out_valid_q || out_ready);
	assign out_valid      = out_valid_q;
	assign out_byte       = out_byte_q;
	assign out_valid_bits = out_bits_q;
	assign out_flushed    = out_flushed_q;

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_byte_q    <= emit_byte;
			out_bits_q    <= emit_bits;
			out_flushed_q <= (head_cmd.action == vlbp_pkg::ACT_FLUSH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q   <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				partial_q <= partial_next;
				fill_q    <= fill_next;
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hw/rtl/variable_length_bit_packer_top.sv
// ----------------------------------------------------------------------------
// Variable-length bit packer
// Packs fields of one to eight bits into bytes, least significant bit first.
// ----------------------------------------------------------------------------
// The block takes one item per clock and gives at most one byte per clock
// when both streams flow; the back end shifts and merges each field
// combinationally. A byte is offered on the output once the item that
// completes it has passed the front register and the command queue and been
// merged; it then sits in the output register until taken. The queue,
// QueueDepth entries deep, absorbs output stalls so the input keeps accepting
// items until it fills.
module variable_length_bit_packer_top #(
	parameter int unsigned QueueDepth = vlbp_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // field_bits[7:0], field_width[11:8], zero pad
	input  logic [1:0]  s_axis_tuser,  // action[0], msb_first[1]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // out_byte[7:0], valid_bits[11:8], zero pad
	output logic [0:0]  m_axis_tuser   // flushed[0]
);

	logic           push;
	logic           pop;
	logic           queue_full;
	logic           queue_empty;
	vlbp_pkg::cmd_t push_cmd;
	vlbp_pkg::cmd_t head_cmd;
	logic [7:0]     out_byte;
	logic [3:0]     out_valid_bits;
	logic           out_flushed;

	vlbp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_action    (vlbp_pkg::action_t'(s_axis_tuser[0])),
		.in_bits      (s_axis_tdata[7:0]),
		.in_width     (s_axis_tdata[11:8]),
		.in_msb_first (s_axis_tuser[1]),
		.push         (push),
		.push_cmd     (push_cmd),
		.queue_full   (queue_full)
	);

	vlbp_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (queue_full),
		.pop      (pop),
		.empty    (queue_empty),
		.head_cmd (head_cmd)
	);

	vlbp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.queue_empty    (queue_empty),
		.head_cmd       (head_cmd),
		.pop            (pop),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_byte       (out_byte),
		.out_valid_bits (out_valid_bits),
		.out_flushed    (out_flushed)
	);

	assign m_axis_tdata = {4'h0, out_valid_bits, out_byte};
	assign m_axis_tuser = out_flushed;

endmodule

FILE: hw/rtl/vlbp_checker.sv
// ----------------------------------------------------------------------------
// Bit packer port checker
// Checks the output stream of the bit packer over time from its ports.
// ----------------------------------------------------------------------------
`include "variable_length_bit_packer_top_assert.svh"

module vlbp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);

	`VLBP_ASSERT_SAME(a_bits_range, clk, arst_n, m_axis_tvalid, (m_axis_tdata[11:8] != 4'h0) && (m_axis_tdata[15:12] == 4'h0) && (m_axis_tdata[11:8] <= 4'h8))
	`VLBP_ASSERT_SAME(a_full_byte, clk, arst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[11:8] == 4'h8)
	`VLBP_ASSERT_SAME(a_flush_clean, clk, arst_n, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata[11:8] != 4'h8) && ((m_axis_tdata[7:0] >> m_axis_tdata[11:8]) == 8'h00))
	`VLBP_ASSERT_NEXT(a_stall_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind variable_length_bit_packer_top vlbp_checker u_vlbp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
